FILE: hw/rtl/csolve_pkg.sv
// Shared types and constants for the 3x3 Cramer solver.
// No dependencies.
package csolve_pkg;

    localparam int SOL_W    = 32;  // result word, signed
    localparam int LANES    = 3;   // one lane per unknown
    localparam int NMAT     = 4;   // A plus A with each column replaced by b

    localparam logic [SOL_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [SOL_W-1:0] NEG_LIMIT = 32'h8000_0000;

    // sideband that rides along the divider stages
    typedef struct packed {
        logic             sing;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] big;
    } t_side;

endpackage

FILE: hw/rtl/csolve_if.sv
// Channel interfaces for the 3x3 Cramer solver: request and response.
// Depends on csolve_pkg.
interface csolve_in_if #(
    parameter int EW = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [EW-1:0] m_r0c0, m_r0c1, m_r0c2;
    logic signed [EW-1:0] m_r1c0, m_r1c1, m_r1c2;
    logic signed [EW-1:0] m_r2c0, m_r2c1, m_r2c2;
    logic signed [EW-1:0] rhs_0, rhs_1, rhs_2;

    modport src (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                 m_r2c0, m_r2c1, m_r2c2, rhs_0, rhs_1, rhs_2, input ready);
    modport snk (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                 m_r2c0, m_r2c1, m_r2c2, rhs_0, rhs_1, rhs_2, output ready);
endinterface

interface csolve_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [csolve_pkg::SOL_W-1:0]    sol_0, sol_1, sol_2;
    logic                                   singular;
    logic                                   overflow;

    modport src (output valid, sol_0, sol_1, sol_2, singular, overflow, input ready);
    modport snk (input valid, sol_0, sol_1, sol_2, singular, overflow, output ready);
endinterface

FILE: hw/rtl/csolve_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor. Depends on csolve_pkg.
module csolve_div #(
    parameter int DW = 51
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_vld,
    input  csolve_pkg::t_side                            i_side,
    input  logic [DW-1:0]                                i_dm,
    input  logic [csolve_pkg::LANES-1:0][DW:0]           i_rem,
    input  logic [csolve_pkg::LANES-1:0][csolve_pkg::SOL_W-1:0] i_xlo,
    output logic                                         o_vld,
    output csolve_pkg::t_side                            o_side,
    output logic [csolve_pkg::LANES-1:0][csolve_pkg::SOL_W-1:0] o_q
);
    localparam int NS = csolve_pkg::SOL_W;
    localparam int L  = csolve_pkg::LANES;

    logic                     r_vld  [0:NS];
    csolve_pkg::t_side        r_side [0:NS];
    logic [DW-1:0]            r_dm   [0:NS];
    logic [L-1:0][DW:0]       r_rem  [0:NS];
    logic [L-1:0][NS-1:0]     r_xlo  [0:NS];
    logic [L-1:0][NS-1:0]     r_q    [0:NS];

    assign r_vld[0]  = i_vld;
    assign r_side[0] = i_side;
    assign r_dm[0]   = i_dm;
    assign r_rem[0]  = i_rem;
    assign r_xlo[0]  = i_xlo;
    assign r_q[0]    = '0;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [L-1:0][DW:0]   n_rem;
        logic [L-1:0][NS-1:0] n_q;

        always_comb begin
            logic [DW:0] v_try;
            v_try = '0;
            for (int l = 0; l < L; l++) begin
                // remainder stays below the divisor, so its top bit is free
                v_try = {r_rem[s][l][DW-1:0], r_xlo[s][l][NS-1]};
                if (v_try >= {1'b0, r_dm[s]}) begin
                    n_rem[l] = v_try - {1'b0, r_dm[s]};
                    n_q[l]   = {r_q[s][l][NS-2:0], 1'b1};
                end else begin
                    n_rem[l] = v_try;
                    n_q[l]   = {r_q[s][l][NS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_side[s+1] <= r_side[s];
                r_dm[s+1]   <= r_dm[s];
                r_rem[s+1]  <= n_rem;
                r_q[s+1]    <= n_q;
                for (int l = 0; l < L; l++) begin
                    r_xlo[s+1][l] <= {r_xlo[s][l][NS-2:0], 1'b0};
                end
            end
        end
    end

    assign o_vld  = r_vld[NS];
    assign o_side = r_side[NS];
    assign o_q    = r_q[NS];

endmodule

FILE: hw/rtl/linear_system_3x3_cramer_solver.sv
// Top level of the 3x3 Cramer solver: determinant pipeline, sign and
// range check, divider, saturation. Depends on csolve_pkg, csolve_if, csolve_div.
//
//  channel   dir  modport  payload
//  i_req     in   snk      m_r0c0..m_r2c2, rhs_0..rhs_2
//  o_rsp     out  src      sol_0..sol_2, singular, overflow
//
// One item per cycle while o_rsp is not stalled; 4 determinant stages, 1 sign stage,
// 32 divider stages and 1 output register.
// Synchronous active-low reset clears only the valid bits.
// A stall at o_rsp freezes the whole pipeline; i_req.ready follows it.
module linear_system_3x3_cramer_solver #(
    parameter int ENTRY_WIDTH   = 16,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csolve_in_if.snk   i_req,
    csolve_out_if.src  o_rsp
);
    localparam int EW = ENTRY_WIDTH;
    localparam int FB = OUT_FRAC_BITS;
    localparam int PW = 2 * EW;          // pair product
    localparam int CW = 2 * EW + 1;      // 2x2 cofactor
    localparam int TW = 3 * EW + 1;      // row times cofactor
    localparam int DW = 3 * EW + 3;      // determinant
    localparam int SW = csolve_pkg::SOL_W;
    localparam int L  = csolve_pkg::LANES;
    localparam int NM = csolve_pkg::NMAT;
    localparam int XW = DW + SW;         // compare width for range check

    logic en;
    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;

    // matrices: 0 is A, k is A with column k-1 replaced by b
    logic signed [EW-1:0] a [3][3];
    logic signed [EW-1:0] b [3];
    logic signed [EW-1:0] m [NM][3][3];

    assign a[0][0] = i_req.m_r0c0; assign a[0][1] = i_req.m_r0c1; assign a[0][2] = i_req.m_r0c2;
    assign a[1][0] = i_req.m_r1c0; assign a[1][1] = i_req.m_r1c1; assign a[1][2] = i_req.m_r1c2;
    assign a[2][0] = i_req.m_r2c0; assign a[2][1] = i_req.m_r2c1; assign a[2][2] = i_req.m_r2c2;
    assign b[0] = i_req.rhs_0; assign b[1] = i_req.rhs_1; assign b[2] = i_req.rhs_2;

    always_comb begin
        for (int k = 0; k < NM; k++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    m[k][r][c] = (k == c + 1) ? b[r] : a[r][c];
                end
            end
        end
    end

    logic signed [PW-1:0] r_p   [NM][6];
    logic signed [EW-1:0] r_row1[NM][3];
    logic signed [CW-1:0] r_cof [NM][3];
    logic signed [EW-1:0] r_row2[NM][3];
    logic signed [TW-1:0] r_t   [NM][3];
    logic signed [DW-1:0] r_det [NM];

    assign en          = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (en) begin
            r_vld1 <= i_req.valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
        if (en) begin
            for (int k = 0; k < NM; k++) begin
                r_p[k][0] <= PW'(m[k][1][1] * m[k][2][2]);
                r_p[k][1] <= PW'(m[k][2][1] * m[k][1][2]);
                r_p[k][2] <= PW'(m[k][1][0] * m[k][2][2]);
                r_p[k][3] <= PW'(m[k][2][0] * m[k][1][2]);
                r_p[k][4] <= PW'(m[k][1][0] * m[k][2][1]);
                r_p[k][5] <= PW'(m[k][2][0] * m[k][1][1]);
                for (int j = 0; j < 3; j++) begin
                    r_row1[k][j] <= m[k][0][j];
                    r_row2[k][j] <= r_row1[k][j];
                    r_cof[k][j]  <= CW'(r_p[k][2*j]) - CW'(r_p[k][2*j+1]);
                    r_t[k][j]    <= TW'(r_row2[k][j] * r_cof[k][j]);
                end
                r_det[k] <= DW'(r_t[k][0]) - DW'(r_t[k][1]) + DW'(r_t[k][2]);
            end
        end
    end

    // sign, magnitude and range check
    logic [DW-1:0]           dm;
    logic [DW-1:0]           nm [L];
    csolve_pkg::t_side       n_side;
    logic [L-1:0][DW:0]      n_rem;
    logic [L-1:0][SW-1:0]    n_xlo;

    always_comb begin
        logic [XW-1:0] v_x;
        v_x = '0;
        dm  = r_det[0][DW-1] ? DW'(-r_det[0]) : DW'(r_det[0]);
        n_side.sing = (r_det[0] == '0);
        for (int l = 0; l < L; l++) begin
            nm[l] = r_det[l+1][DW-1] ? DW'(-r_det[l+1]) : DW'(r_det[l+1]);
            n_side.neg[l] = r_det[l+1][DW-1] ^ r_det[0][DW-1];
            v_x = XW'(nm[l]) << FB;
            // quotient of 2^32 or more cannot fit in any case
            n_side.big[l] = (v_x >= {dm, {SW{1'b0}}});
            n_rem[l] = (DW+1)'(v_x >> SW);
            n_xlo[l] = v_x[SW-1:0];
        end
    end

    csolve_pkg::t_side     r_side5;
    logic [DW-1:0]         r_dm5;
    logic [L-1:0][DW:0]    r_rem5;
    logic [L-1:0][SW-1:0]  r_xlo5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
        end else if (en) begin
            r_vld5 <= r_vld4;
        end
        if (en) begin
            r_side5 <= n_side;
            r_dm5   <= dm;
            r_rem5  <= n_rem;
            r_xlo5  <= n_xlo;
        end
    end

    logic                  d_vld;
    csolve_pkg::t_side     d_side;
    logic [L-1:0][SW-1:0]  d_q;

    csolve_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vld5),
        .i_side  (r_side5),
        .i_dm    (r_dm5),
        .i_rem   (r_rem5),
        .i_xlo   (r_xlo5),
        .o_vld   (d_vld),
        .o_side  (d_side),
        .o_q     (d_q)
    );

    // saturation and final sign
    logic [L-1:0][SW-1:0] n_sol;
    logic                 n_ovf;

    always_comb begin
        logic [SW-1:0] v_lim;
        logic [SW-1:0] v_mag;
        n_ovf = 1'b0;
        v_lim = '0;
        v_mag = '0;
        for (int l = 0; l < L; l++) begin
            v_lim = d_side.neg[l] ? csolve_pkg::NEG_LIMIT : csolve_pkg::POS_LIMIT;
            if (d_side.big[l] || d_q[l] > v_lim) begin
                v_mag = v_lim;
                n_ovf = 1'b1;
            end else begin
                v_mag = d_q[l];
            end
            n_sol[l] = d_side.neg[l] ? SW'(-v_mag) : v_mag;
        end
        if (d_side.sing) begin
            n_sol = '0;
            n_ovf = 1'b0;
        end
    end

    logic                 r_ovld;
    logic [L-1:0][SW-1:0] r_sol;
    logic                 r_sing;
    logic                 r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= d_vld;
        end
        if (en) begin
            r_sol  <= n_sol;
            r_sing <= d_side.sing;
            r_ovf  <= n_ovf;
        end
    end

    assign o_rsp.valid    = r_ovld;
    assign o_rsp.sol_0    = r_sol[0];
    assign o_rsp.sol_1    = r_sol[1];
    assign o_rsp.sol_2    = r_sol[2];
    assign o_rsp.singular = r_sing;
    assign o_rsp.overflow = r_ovf;

`ifndef SYNTH
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.singular |->
            o_rsp.sol_0 == '0 && o_rsp.sol_1 == '0 && o_rsp.sol_2 == '0 && !o_rsp.overflow)
        else $error("singular result carries nonzero data");
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_rsp.valid)
        else $error("result valid right after reset");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(r_sol))
        else $error("stalled result lost or changed");
`endif

endmodule

FILE: bench/csolve_checker.sv
// Checker for the 3x3 Cramer solver: watches both channels, predicts each
// solution from the accepted matrix and compares. Depends on csolve_pkg, csolve_if.
`timescale 1ns / 100ps

module csolve_checker #(
    parameter int EW = 16,
    parameter int FB = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csolve_in_if       i_req,
    csolve_out_if      o_rsp,
    output int         o_fails,
    output int         o_pending
);

    typedef struct packed {
        logic [csolve_pkg::SOL_W-1:0] s0, s1, s2;
        logic                         sing;
        logic                         ovf;
    } t_sol;

    t_sol sol_q[$];
    int   fails = 0;

    assign o_fails   = fails;
    assign o_pending = sol_q.size();

    // exact 3x3 determinant; products of three 16-bit entries fit in 128 bits
    function automatic logic signed [127:0] det_3x3(logic signed [127:0] m[3][3]);
        return m[0][0] * (m[1][1] * m[2][2] - m[2][1] * m[1][2])
             - m[0][1] * (m[1][0] * m[2][2] - m[2][0] * m[1][2])
             + m[0][2] * (m[1][0] * m[2][1] - m[2][0] * m[1][1]);
    endfunction

    function automatic t_sol solve_cramer(logic signed [EW-1:0] e[12]);
        logic signed [127:0]          a[3][3], t[3][3];
        logic signed [127:0]          d, n;
        logic        [255:0]          dm, nm, q;
        logic                         neg;
        t_sol                         r;
        logic [csolve_pkg::SOL_W-1:0] v[3];
        r = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = e[i*3+j];
        d = det_3x3(a);
        if (d == 0) begin
            r.sing = 1'b1;
            return r;
        end
        dm = (d < 0) ? -d : d;
        for (int k = 0; k < 3; k++) begin
            t = a;
            for (int i = 0; i < 3; i++)
                t[i][k] = e[9+i];
            n   = det_3x3(t);
            neg = (n < 0) != (d < 0);
            nm  = (n < 0) ? -n : n;
            q   = (nm << FB) / dm;
            if (!neg && q > 256'h7FFF_FFFF) begin
                v[k] = csolve_pkg::POS_LIMIT;
                r.ovf = 1'b1;
            end else if (neg && q > 256'h8000_0000) begin
                v[k] = csolve_pkg::NEG_LIMIT;
                r.ovf = 1'b1;
            end else begin
                v[k] = neg ? -q[csolve_pkg::SOL_W-1:0] : q[csolve_pkg::SOL_W-1:0];
            end
        end
        r.s0 = v[0];
        r.s1 = v[1];
        r.s2 = v[2];
        return r;
    endfunction

    always @(posedge i_clk) begin
        logic signed [EW-1:0] e[12];
        t_sol got, want;
        if (i_rst_n && i_req.valid && i_req.ready) begin
            e = '{i_req.m_r0c0, i_req.m_r0c1, i_req.m_r0c2,
                  i_req.m_r1c0, i_req.m_r1c1, i_req.m_r1c2,
                  i_req.m_r2c0, i_req.m_r2c1, i_req.m_r2c2,
                  i_req.rhs_0, i_req.rhs_1, i_req.rhs_2};
            sol_q.push_back(solve_cramer(e));
        end
        if (i_rst_n && o_rsp.valid && o_rsp.ready) begin
            got = '{o_rsp.sol_0, o_rsp.sol_1, o_rsp.sol_2, o_rsp.singular,
                    o_rsp.overflow};
            if (sol_q.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected solution transfer: %h", got);
            end else begin
                want = sol_q.pop_front();
                if (got !== want) begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: sol %h %h %h sing %b ovf %b, exp %h %h %h sing %b ovf %b",
                                 got.s0, got.s1, got.s2, got.sing, got.ovf,
                                 want.s0, want.s1, want.s2, want.sing, want.ovf);
                end
            end
        end
    end
endmodule

FILE: bench/tb_linear_system_3x3_cramer_solver.sv
// Top of the Cramer solver bench: clock, reset, matrix stimulus, response
// back-pressure and verdict. Depends on csolve_pkg, csolve_if, csolve_checker.
`timescale 1ns / 100ps

module tb_linear_system_3x3_cramer_solver;
    localparam int EW        = 16;
    localparam int LATENCY   = 38;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 2000;

    logic i_clk;
    logic i_rst_n;
    int   fails, pending;
    int   idle_cycles;
    logic hold_rsp;

    csolve_in_if #(.EW(EW)) req_if ();
    csolve_out_if           rsp_if ();

    linear_system_3x3_cramer_solver #(.ENTRY_WIDTH(EW), .OUT_FRAC_BITS(16)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    csolve_checker #(.EW(EW), .FB(16)) i_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req_if),
        .o_rsp    (rsp_if),
        .o_fails  (fails),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // mostly small entries so systems stay solvable in range; some full range
    function automatic logic [EW-1:0] rand_entry(int mode);
        case (mode)
            0: return EW'($urandom);
            1: return EW'($signed($urandom_range(0, 2047)) - 1024);
            2: return EW'($signed($urandom_range(0, 15)) - 8);
            default: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    task automatic send_item(logic [EW-1:0] e[12]);
        req_if.m_r0c0 <= e[0]; req_if.m_r0c1 <= e[1]; req_if.m_r0c2 <= e[2];
        req_if.m_r1c0 <= e[3]; req_if.m_r1c1 <= e[4]; req_if.m_r1c2 <= e[5];
        req_if.m_r2c0 <= e[6]; req_if.m_r2c1 <= e[7]; req_if.m_r2c2 <= e[8];
        req_if.rhs_0  <= e[9]; req_if.rhs_1  <= e[10]; req_if.rhs_2 <= e[11];
        req_if.valid  <= 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int n);
        req_if.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain_wait();
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // response back-pressure, including one long hold-off
    initial begin
        int n;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                rsp_if.ready <= 1'b0;
                repeat (200) @(negedge i_clk);
                hold_rsp = 1'b0;
            end
            n = gap_len();
            if (n == 0 || $urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    // watchdog on stalled traffic
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("tb_linear_system_3x3_cramer_solver: FAIL");
            $finish;
        end
    end

    initial begin
        logic [EW-1:0] e[12];
        int mode;
        hold_rsp  = 1'b0;
        idle_cycles = 0;
        req_if.valid = 1'b0;
        {req_if.m_r0c0, req_if.m_r0c1, req_if.m_r0c2, req_if.m_r1c0, req_if.m_r1c1,
         req_if.m_r1c2, req_if.m_r2c0, req_if.m_r2c1, req_if.m_r2c2,
         req_if.rhs_0, req_if.rhs_1, req_if.rhs_2} = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: identity, zero matrix, singular rows, extremes, overflow
        e = '{16'h0100, '0, '0, '0, 16'h0100, '0, '0, '0, 16'h0100,
              16'h7FFF, 16'h8000, 16'h0001};
        send_item(e);
        e = '{default: 16'h0000};
        send_item(e);
        e = '{default: 16'h7FFF};
        send_item(e);
        e = '{default: 16'h8000};
        send_item(e);
        e = '{default: 16'hFFFF};
        send_item(e);
        e = '{16'h0001, '0, '0, '0, 16'h0001, '0, '0, '0, 16'h0001,
              16'h7FFF, 16'h8000, 16'h7FFF};
        send_item(e);
        e = '{16'h0001, '0, '0, '0, 16'hFFFF, '0, '0, '0, 16'h0001,
              16'h8000, 16'h8000, 16'h0000};
        send_item(e);
        e = '{16'h0100, 16'h0200, 16'h0300, 16'h0200, 16'h0400, 16'h0600,
              16'h0001, 16'h0005, 16'h0007, 16'h0100, 16'h0100, 16'h0100};
        send_item(e);
        e = '{16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001,
              16'h0003, 16'hFFFD, 16'h0002, 16'h5555, 16'hAAAA, 16'h1234};
        send_item(e);
        e = '{16'h0003, 16'h0001, 16'h0000, 16'h0001, 16'h0003, 16'h0000,
              16'h0000, 16'h0000, 16'h0007, 16'h0001, 16'hFFFF, 16'h0002};
        send_item(e);
        e = '{16'h8000, '0, '0, '0, 16'h8000, '0, '0, '0, 16'h8000,
              16'h8000, 16'h7FFF, 16'h8000};
        send_item(e);

        // sender pauses until every expected solution is back
        drain_wait();

        for (int k = 0; k < N_RANDOM; k++) begin
            int g;
            if (k == 300) hold_rsp = 1'b1;
            if (k == 1200) drain_wait();
            mode = $urandom_range(0, 9);
            mode = (mode < 3) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
            foreach (e[j]) e[j] = rand_entry(mode);
            // occasionally force a singular matrix by copying a row
            if ($urandom_range(0, 19) == 0) begin
                e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
            end
            send_item(e);
            g = gap_len();
            if (g != 0) pause_sender(g);
        end
        req_if.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fails == 0)
            $display("tb_linear_system_3x3_cramer_solver: PASS");
        else
            $display("tb_linear_system_3x3_cramer_solver: FAIL");
        $finish;
    end
endmodule
